// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2,
        OP_SET    = 2'd3
    } t_op;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] FILL_COLOR   = 8'h02;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] char_code;
        logic [7:0] color;
        logic [4:0] target_row;
        logic [6:0] target_col;
    } t_in;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic       scrolled;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic ptr_inc;
        logic ptr_clr;
        logic prime;
        logic copy;
        logic fill;
        logic clear_wr;
        logic clear_top;
        logic cap_cell;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_clear;
        logic is_read;
        logic need_scroll;
        logic ptr_copy_last;
        logic ptr_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/text_console_writer.sv =====
// channel   dir  handshake                 payload
// in        in   i_in_valid / o_in_ready   i_in  (tcw_pkg::t_in)
// out       out  o_out_valid / i_out_ready o_out (tcw_pkg::t_out)
//
// one item at a time; plain append or set cursor: accept, then done;
// read cell: accept, read, done; scroll (prime, copy, fill) and clear sweep
// the screen ram one cell per cycle (one write, one read port)
// after reset a pass clears all ROWS*COLUMNS cells while o_in_ready is low
// a result waits in the output register; the next item is accepted and
// stalls in its last step until the waiting transfer completes
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tcw_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tcw_pkg::t_out o_out
);

    tcw_pkg::t_cmd cmd;
    tcw_pkg::t_sts sts;

    tcw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    tcw_dp #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_out      (o_out)
    );

endmodule

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcw_ctrl.sv =====
module tcw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tcw_pkg::t_sts i_sts,
    output tcw_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_PRIME,
        S_COPY,
        S_FILL,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic          r_ready;
    tcw_pkg::t_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        case (r_state)
            S_INIT, S_CLEAR: begin
                n_cmd.clear_wr  = 1'b1;
                n_cmd.clear_top = (r_state == S_CLEAR);
                if (i_sts.ptr_last) begin
                    n_cmd.ptr_clr = 1'b1;
                    n_state       = (r_state == S_CLEAR) ? S_DONE : S_IDLE;
                end else begin
                    n_cmd.ptr_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    n_cmd.accept = 1'b1;
                    if (i_sts.is_clear) begin
                        n_state = S_CLEAR;
                    end else if (i_sts.is_read) begin
                        n_state = S_READ;
                    end else if (i_sts.need_scroll) begin
                        n_state = S_PRIME;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: begin
                n_cmd.cap_cell = 1'b1;
                n_state        = S_DONE;
            end
            S_PRIME: begin
                n_cmd.prime = 1'b1;
                n_state     = S_COPY;
            end
            S_COPY: begin
                n_cmd.copy    = 1'b1;
                n_cmd.ptr_inc = 1'b1;
                if (i_sts.ptr_copy_last) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                n_cmd.fill = 1'b1;
                if (i_sts.ptr_last) begin
                    n_cmd.ptr_clr = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    n_cmd.ptr_inc = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_ready;
    assign o_cmd      = n_cmd;

endmodule

// ===== rtl/tcw_dp.sv =====
module tcw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tcw_pkg::t_in  i_in,
    input  tcw_pkg::t_cmd i_cmd,
    output tcw_pkg::t_sts o_sts,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output tcw_pkg::t_out o_out
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [AW-1:0] L_COLS      = AW'(COLUMNS);
    localparam logic [AW-1:0] L_COPY_LAST = AW'((ROWS - 1) * COLUMNS - 1);
    localparam logic [AW-1:0] L_LAST      = AW'(CELLS - 1);
    localparam logic [4:0]    L_LAST_ROW  = 5'(ROWS - 1);
    localparam logic [6:0]    L_LAST_COL  = 7'(COLUMNS - 1);

    logic [4:0]    r_row;
    logic [6:0]    r_col;
    logic [4:0]    n_row;
    logic [6:0]    n_col;
    logic [AW-1:0] r_ptr;
    logic          r_scrolled;
    logic [7:0]    r_cell_char;
    logic [7:0]    r_cell_color;
    logic          r_out_valid;
    tcw_pkg::t_out r_out;

    logic [4:0]    trow;
    logic [6:0]    tcol;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] tgt_addr;
    logic          is_append;
    logic          is_newline;
    logic          need_scroll;
    logic          out_free;

    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic [AW-1:0] raddr;
    logic [15:0]   rdata;

    assign trow = (i_in.target_row > L_LAST_ROW) ? L_LAST_ROW : i_in.target_row;
    assign tcol = (i_in.target_col > L_LAST_COL) ? L_LAST_COL : i_in.target_col;

    assign cur_addr = AW'(r_row) * L_COLS + AW'(r_col);
    assign tgt_addr = AW'(trow) * L_COLS + AW'(tcol);

    assign is_append  = (i_in.op == tcw_pkg::OP_APPEND);
    assign is_newline = (i_in.char_code == tcw_pkg::NEWLINE_CODE);

    assign need_scroll = is_append && (r_row >= L_LAST_ROW) &&
                         (is_newline || (r_col >= L_LAST_COL));

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        case (i_in.op)
            tcw_pkg::OP_APPEND: begin
                if (is_newline || (r_col >= L_LAST_COL)) begin
                    n_col = '0;
                    n_row = (r_row >= L_LAST_ROW) ? L_LAST_ROW : r_row + 5'd1;
                end else begin
                    n_col = r_col + 7'd1;
                end
            end
            tcw_pkg::OP_CLEAR: begin
                n_row = '0;
                n_col = '0;
            end
            tcw_pkg::OP_SET: begin
                n_row = trow;
                n_col = tcol;
            end
            default: begin
                n_row = r_row;
                n_col = r_col;
            end
        endcase
    end

    // screen store write and read ports
    always_comb begin
        we    = 1'b0;
        waddr = r_ptr;
        wdata = '0;
        raddr = tgt_addr;
        if (i_cmd.accept && is_append && !is_newline) begin
            we    = 1'b1;
            waddr = cur_addr;
            wdata = {i_in.color, i_in.char_code};
        end else if (i_cmd.copy) begin
            we    = 1'b1;
            wdata = rdata;
        end else if (i_cmd.fill) begin
            we    = 1'b1;
            wdata = {tcw_pkg::FILL_COLOR, 8'd0};
        end else if (i_cmd.clear_wr) begin
            we    = 1'b1;
            wdata = (i_cmd.clear_top && (r_ptr == '0)) ? {tcw_pkg::FILL_COLOR, 8'd0} : '0;
        end
        if (i_cmd.prime) begin
            raddr = L_COLS;
        end else if (i_cmd.copy) begin
            raddr = (r_ptr == L_COPY_LAST) ? '0 : r_ptr + L_COLS + AW'(1);
        end
    end

    tcw_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + AW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_scrolled   <= need_scroll;
            r_cell_char  <= '0;
            r_cell_color <= '0;
        end else if (i_cmd.cap_cell) begin
            r_cell_char  <= rdata[7:0];
            r_cell_color <= rdata[15:8];
        end
        if (i_cmd.load_out) begin
            r_out.cursor_row <= r_row;
            r_out.cursor_col <= r_col;
            r_out.scrolled   <= r_scrolled;
            r_out.cell_char  <= r_cell_char;
            r_out.cell_color <= r_cell_color;
        end
    end

    assign o_sts.is_clear      = (i_in.op == tcw_pkg::OP_CLEAR);
    assign o_sts.is_read       = (i_in.op == tcw_pkg::OP_READ);
    assign o_sts.need_scroll   = need_scroll;
    assign o_sts.ptr_copy_last = (r_ptr == L_COPY_LAST);
    assign o_sts.ptr_last      = (r_ptr == L_LAST);
    assign o_sts.out_free      = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/tcw_checker.sv =====
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input tcw_pkg::t_in  i_in,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input tcw_pkg::t_out i_out
);

    localparam logic [4:0] L_LAST_ROW = 5'(ROWS - 1);
    localparam logic [6:0] L_LAST_COL = 7'(COLUMNS - 1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("result changed before its transfer");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out.cursor_row <= L_LAST_ROW) && (i_out.cursor_col <= L_LAST_COL))
        else $error("cursor out of range");

    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.scrolled |->
            (i_out.cursor_row == L_LAST_ROW) && (i_out.cursor_col == 7'd0))
        else $error("scroll with cursor off the bottom row start");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tcw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .i_in_ready (o_in_ready),
    .i_in       (i_in),
    .i_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .i_out      (o_out)
);
